>>> sv/ple_pkg.sv
// Package for the positional list engine: transfer payload types, op and
// status codes, and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	// Operation codes carried in the op field
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// Status codes returned with every result
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BOUNDS   = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_FOUND    = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;

	typedef struct packed {
		logic [1:0]         op;
		logic [4:0]         position;
		logic signed [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] count;
	} rsp_item_t;

	// Walk index update
	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_POSM1,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	// Memory read address selection
	typedef enum logic [1:0] {
		RD_NONE,
		RD_PREV,
		RD_NEXT,
		RD_HERE
	} rd_op_t;

	// Memory write selection
	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_VALUE
	} wr_op_t;

	typedef struct packed {
		logic       capture;
		idx_op_t    idx_op;
		rd_op_t     rd_op;
		wr_op_t     wr_op;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;
		logic [2:0] res_status;
	} dp_ctrl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       ins_bad;
		logic       del_bad;
		logic       ins_more;
		logic       del_more;
		logic       srch_more;
		logic       match;
		logic       out_free;
	} dp_stat_t;

endpackage

>>> sv/positional_list_engine_unit.sv
// A command that only returns a status (list full, list empty, out of bounds,
// unused op code) goes from decode straight to the result; an insert, delete or
// search first walks the list, one shift or compare per entry, and a search
// stops at the first match. One command at a time: the next transfer can be
// taken in the cycle after the result is loaded.
// Reset (arst_n, asynchronous): list empty, no result pending; memory not cleared.
`timescale 1ns / 1ps

module positional_list_engine_unit #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  ple_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ple_pkg::rsp_item_t rsp
);

	logic              ready;
	ple_pkg::dp_ctrl_t ctrl;
	ple_pkg::dp_stat_t stat;

	assign cmd_stall = !ready;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.ready     (ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	ple_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule

>>> sv/ple_datapath.sv
// Datapath of the positional list engine: entry memory, entry count, walk
// index, captured command and the result register.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ple_pkg::cmd_item_t    cmd,
	input  logic                  rsp_stall,
	output logic                  rsp_valid,
	output ple_pkg::rsp_item_t    rsp,
	input  ple_pkg::dp_ctrl_t     ctrl,
	output ple_pkg::dp_stat_t     stat
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = CW + 6;

	logic [31:0]         mem [DEPTH];
	logic [31:0]         rdata_q;
	ple_pkg::cmd_item_t  cmd_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic                out_valid_q;
	ple_pkg::rsp_item_t  rsp_q;

	logic [PW-1:0]       pos_w, cnt_w, idx_w, pos_m1;
	logic [CW-1:0]       idx_prev, idx_next;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [31:0]         wr_data;
	logic [CW+4:0]       cnt_ext;

	// Widened operands for bounds and walk compares
	assign pos_w    = PW'(cmd_q.position);
	assign cnt_w    = PW'(count_q);
	assign idx_w    = PW'(idx_q);
	assign pos_m1   = pos_w - PW'(1);
	assign idx_prev = idx_q - CW'(1);
	assign idx_next = idx_q + CW'(1);

	// Status to the controller
	always_comb begin
		stat.op        = cmd_q.op;
		stat.full      = (count_q == CW'(DEPTH));
		stat.empty     = (count_q == '0);
		stat.ins_bad   = (pos_w == '0) || (pos_w > cnt_w + PW'(1));
		stat.del_bad   = (pos_w == '0) || (pos_w > cnt_w);
		stat.ins_more  = (idx_w >= pos_w);
		stat.del_more  = (idx_w + PW'(1) < cnt_w);
		stat.srch_more = (idx_w < cnt_w);
		stat.match     = (rdata_q == cmd_q.value);
		stat.out_free  = !out_valid_q || !rsp_stall;
	end

	// Captured command
	always_ff @(posedge clk) begin
		if (ctrl.capture) cmd_q <= cmd;
	end

	// Entry count and walk index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctrl.cnt_inc) count_q <= count_q + CW'(1);
			else if (ctrl.cnt_dec) count_q <= count_q - CW'(1);
			case (ctrl.idx_op)
				ple_pkg::IDX_COUNT: idx_q <= count_q;
				ple_pkg::IDX_POSM1: idx_q <= pos_m1[CW-1:0];
				ple_pkg::IDX_ZERO:  idx_q <= '0;
				ple_pkg::IDX_INC:   idx_q <= idx_next;
				ple_pkg::IDX_DEC:   idx_q <= idx_prev;
				default:            idx_q <= idx_q;
			endcase
		end
	end

	// Memory address and data selection
	always_comb begin
		case (ctrl.rd_op)
			ple_pkg::RD_PREV: rd_addr = idx_prev[AW-1:0];
			ple_pkg::RD_NEXT: rd_addr = idx_next[AW-1:0];
			default:          rd_addr = idx_q[AW-1:0];
		endcase
		case (ctrl.wr_op)
			ple_pkg::WR_VALUE: begin
				wr_addr = pos_m1[AW-1:0];
				wr_data = cmd_q.value;
			end
			default: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = rdata_q;
			end
		endcase
	end

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctrl.wr_op != ple_pkg::WR_NONE) mem[wr_addr] <= wr_data;
		if (ctrl.rd_op != ple_pkg::RD_NONE) rdata_q <= mem[rd_addr];
	end

	// Result register
	assign cnt_ext = {5'd0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			rsp_q.status <= ctrl.res_status;
			rsp_q.count  <= cnt_ext[4:0];
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_cnt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.cnt_inc && ctrl.cnt_dec))
		else $error("count incremented and decremented together");

	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.res_load |-> (!out_valid_q || !rsp_stall))
		else $error("result loaded over a pending transfer");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cnt_inc |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the count");

endmodule

>>> sv/ple_ctrl.sv
// Controller of the positional list engine: sequences decode, shift walks,
// search walk and result hand-off.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               ready,
	input  ple_pkg::dp_stat_t  stat,
	output ple_pkg::dp_ctrl_t  ctrl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_INS_WR,
		S_DEL_CHK,
		S_DEL_WR,
		S_SRCH_CHK,
		S_SRCH_CMP,
		S_RESULT
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;

	assign ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		code_d          = code_q;
		ctrl            = '0;
		ctrl.idx_op     = ple_pkg::IDX_HOLD;
		ctrl.rd_op      = ple_pkg::RD_NONE;
		ctrl.wr_op      = ple_pkg::WR_NONE;
		ctrl.res_status = code_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctrl.capture = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					ple_pkg::OP_INSERT: begin
						if (stat.full) begin
							code_d  = ple_pkg::ST_FULL;
							state_d = S_RESULT;
						end else if (stat.ins_bad) begin
							code_d  = ple_pkg::ST_BOUNDS;
							state_d = S_RESULT;
						end else begin
							ctrl.idx_op = ple_pkg::IDX_COUNT;
							state_d     = S_INS_CHK;
						end
					end
					ple_pkg::OP_DELETE: begin
						if (stat.empty) begin
							code_d  = ple_pkg::ST_EMPTY;
							state_d = S_RESULT;
						end else if (stat.del_bad) begin
							code_d  = ple_pkg::ST_BOUNDS;
							state_d = S_RESULT;
						end else begin
							ctrl.idx_op = ple_pkg::IDX_POSM1;
							state_d     = S_DEL_CHK;
						end
					end
					ple_pkg::OP_SEARCH: begin
						ctrl.idx_op = ple_pkg::IDX_ZERO;
						state_d     = S_SRCH_CHK;
					end
					default: begin
						code_d  = ple_pkg::ST_BOUNDS;
						state_d = S_RESULT;
					end
				endcase
			end
			// shift tail entries up, then drop the value in
			S_INS_CHK: begin
				if (stat.ins_more) begin
					ctrl.rd_op = ple_pkg::RD_PREV;
					state_d    = S_INS_WR;
				end else begin
					ctrl.wr_op   = ple_pkg::WR_VALUE;
					ctrl.cnt_inc = 1'b1;
					code_d       = ple_pkg::ST_OK;
					state_d      = S_RESULT;
				end
			end
			S_INS_WR: begin
				ctrl.wr_op  = ple_pkg::WR_SHIFT;
				ctrl.idx_op = ple_pkg::IDX_DEC;
				state_d     = S_INS_CHK;
			end
			// close the gap by shifting later entries down
			S_DEL_CHK: begin
				if (stat.del_more) begin
					ctrl.rd_op = ple_pkg::RD_NEXT;
					state_d    = S_DEL_WR;
				end else begin
					ctrl.cnt_dec = 1'b1;
					code_d       = ple_pkg::ST_OK;
					state_d      = S_RESULT;
				end
			end
			S_DEL_WR: begin
				ctrl.wr_op  = ple_pkg::WR_SHIFT;
				ctrl.idx_op = ple_pkg::IDX_INC;
				state_d     = S_DEL_CHK;
			end
			// linear scan from the head
			S_SRCH_CHK: begin
				if (stat.srch_more) begin
					ctrl.rd_op = ple_pkg::RD_HERE;
					state_d    = S_SRCH_CMP;
				end else begin
					code_d  = ple_pkg::ST_NOTFOUND;
					state_d = S_RESULT;
				end
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					code_d  = ple_pkg::ST_FOUND;
					state_d = S_RESULT;
				end else begin
					ctrl.idx_op = ple_pkg::IDX_INC;
					state_d     = S_SRCH_CHK;
				end
			end
			S_RESULT: begin
				if (stat.out_free) begin
					ctrl.res_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and registered status code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ple_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// Checks
	a_cap_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> (state_q == S_DECODE))
		else $error("capture did not lead to decode");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.res_load |-> (state_q == S_RESULT && stat.out_free))
		else $error("result loaded outside hand-off");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.rd_op != ple_pkg::RD_NONE && ctrl.wr_op != ple_pkg::WR_NONE))
		else $error("read and write issued in one cycle");

endmodule

>>> tb/sv/ple_list_checker.sv
// Checker for the positional list engine: watches both channels, keeps its own
// copy of the list, predicts each result and compares field by field.
// Depends on ple_pkg for the payload structs and the op and status codes.
`timescale 1ns / 1ps

module ple_list_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  ple_pkg::cmd_item_t cmd,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  ple_pkg::rsp_item_t rsp,
	output int                 fail_count,
	output int                 outstanding,
	output int                 list_len_now,
	output int                 checked,
	output int                 full_hits,
	output int                 found_hits
);

	// Shadow list; only entries below list_len are ever read
	logic signed [31:0]  list_vals [DEPTH];
	int                  list_len = 0;
	ple_pkg::rsp_item_t  rsp_expected_q [$];

	// Apply one command to the shadow list and return the result it gives
	function automatic ple_pkg::rsp_item_t apply_list_cmd(ple_pkg::cmd_item_t c);
		ple_pkg::rsp_item_t r;
		int                 p;
		int                 i;
		logic               hit;
		p = c.position;
		r.status = ple_pkg::ST_BOUNDS;
		case (c.op)
			ple_pkg::OP_INSERT: begin
				if (list_len >= DEPTH) begin
					r.status = ple_pkg::ST_FULL;
				end else if (p >= 1 && p <= list_len + 1) begin
					for (i = list_len; i > p - 1; i--)
						list_vals[i] = list_vals[i - 1];
					list_vals[p - 1] = c.value;
					list_len++;
					r.status = ple_pkg::ST_OK;
				end
			end
			ple_pkg::OP_DELETE: begin
				if (list_len == 0) begin
					r.status = ple_pkg::ST_EMPTY;
				end else if (p >= 1 && p <= list_len) begin
					for (i = p - 1; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i + 1];
					list_len--;
					r.status = ple_pkg::ST_OK;
				end
			end
			ple_pkg::OP_SEARCH: begin
				hit = 1'b0;
				for (i = 0; i < list_len; i++)
					if (list_vals[i] == c.value)
						hit = 1'b1;
				r.status = hit ? ple_pkg::ST_FOUND : ple_pkg::ST_NOTFOUND;
			end
			default: ;  // unused op code: out of bounds, no change
		endcase
		r.count = 5'(list_len);
		return r;
	endfunction

	initial begin
		fail_count   = 0;
		outstanding  = 0;
		list_len_now = 0;
		checked      = 0;
		full_hits    = 0;
		found_hits   = 0;
	end

	// Results are checked before the new command is predicted; a result can
	// never leave in the same cycle as its own command arrives
	always @(posedge clk or negedge arst_n) begin
		ple_pkg::rsp_item_t want;
		if (!arst_n) begin
			list_len = 0;
			rsp_expected_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected_q.size() == 0) begin
					$display("%0t: result with nothing expected: status %0d count %0d",
						$time, rsp.status, rsp.count);
					fail_count++;
				end else begin
					want = rsp_expected_q.pop_front();
					checked++;
					if (rsp.status !== want.status || rsp.count !== want.count) begin
						$display({"%0t: mismatch: expected status %0d count %0d,",
							" got status %0d count %0d"},
							$time, want.status, want.count, rsp.status, rsp.count);
						fail_count++;
					end
					if (want.status == ple_pkg::ST_FULL)
						full_hits++;
					if (want.status == ple_pkg::ST_FOUND)
						found_hits++;
				end
			end
			if (cmd_valid && !cmd_stall)
				rsp_expected_q.push_back(apply_list_cmd(cmd));
		end
		outstanding  = rsp_expected_q.size();
		list_len_now = list_len;
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the positional list engine testbench: clock, reset, command stimulus,
// random stall on the result side and the final verdict.
// Depends on ple_pkg, positional_list_engine_unit and ple_list_checker.
`timescale 1ns / 1ps

module testbench;

	localparam int         DEPTH      = 16;
	localparam int         RAND_ITEMS = 1400;
	localparam int         CALM_ITEMS = 150;
	localparam int         LIMIT      = 400000;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	ple_pkg::cmd_item_t cmd;
	logic               rsp_valid;
	logic               rsp_stall;
	ple_pkg::rsp_item_t rsp;

	int fail_count;
	int outstanding;
	int list_len_now;
	int checked;
	int full_hits;
	int found_hits;

	int cycles   = 0;
	int sent     = 0;
	bit idle_on  = 1'b1;

	positional_list_engine_unit #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	ple_list_checker #(.DEPTH(DEPTH)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.list_len_now (list_len_now),
		.checked      (checked),
		.full_hits    (full_hits),
		.found_hits   (found_hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		cycles++;

	// Watchdog
	initial begin
		while (cycles < LIMIT)
			@(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// Result side: random stall bursts
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				burst--;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 2);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic ple_pkg::cmd_item_t mk_cmd(logic [1:0] op, int pos, logic [31:0] val);
		ple_pkg::cmd_item_t c;
		c.op       = op;
		c.position = 5'(pos);
		c.value    = val;
		return c;
	endfunction

	// Small pool of values so that searches hit often; extremes included
	function automatic logic [31:0] pool_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			5: return 32'h5555_5555;
			6: return 32'hAAAA_AAAA;
			default: return 32'd42;
		endcase
	endfunction

	// Random command; mode 0 tilts toward insert, 1 toward delete, 2 mixed
	function automatic ple_pkg::cmd_item_t rand_cmd(int mode, int len);
		ple_pkg::cmd_item_t c;
		int                 pick;
		logic [1:0]         op;
		int                 pos;
		logic [31:0]        val;
		pick = $urandom_range(0, 99);
		case (mode)
			0:       op = pick < 70 ? ple_pkg::OP_INSERT : pick < 85 ? ple_pkg::OP_DELETE :
				pick < 98 ? ple_pkg::OP_SEARCH : OP_UNUSED;
			1:       op = pick < 70 ? ple_pkg::OP_DELETE : pick < 85 ? ple_pkg::OP_INSERT :
				pick < 98 ? ple_pkg::OP_SEARCH : OP_UNUSED;
			default: op = pick < 35 ? ple_pkg::OP_INSERT : pick < 65 ? ple_pkg::OP_DELETE :
				pick < 97 ? ple_pkg::OP_SEARCH : OP_UNUSED;
		endcase
		pos = $urandom_range(0, 31);
		if ($urandom_range(0, 99) < 85) begin
			if (op == ple_pkg::OP_INSERT && len < DEPTH)
				pos = $urandom_range(1, len + 1);
			else if (op == ple_pkg::OP_DELETE && len > 0)
				pos = $urandom_range(1, len);
		end
		val = $urandom_range(0, 1) ? pool_value() : $urandom;
		c = mk_cmd(op, pos, val);
		return c;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic send_cmd(ple_pkg::cmd_item_t c);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		sent++;
		@(negedge clk);
	endtask

	// Sender holds off until every expected result has arrived
	task automatic drain_pause();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	initial begin
		int mode;
		int n;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		rsp_stall = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty list, bounds on both sides, head, middle and tail
		send_cmd(mk_cmd(ple_pkg::OP_DELETE, 1, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_DELETE, 0, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_SEARCH, 0, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 0, 32'h1234_5678));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 2, 32'h1234_5678));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 1, 32'h8000_0000));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 2, 32'h7FFF_FFFF));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 1, 32'hFFFF_FFFF));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 2, 32'h0000_0000));
		send_cmd(mk_cmd(ple_pkg::OP_INSERT, 31, 32'hFFFF_FFFF));
		send_cmd(mk_cmd(OP_UNUSED, 31, 32'hFFFF_FFFF));
		send_cmd(mk_cmd(OP_UNUSED, 0, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_SEARCH, 31, 32'h8000_0000));
		send_cmd(mk_cmd(ple_pkg::OP_SEARCH, 0, 32'h7FFF_FFFF));
		send_cmd(mk_cmd(ple_pkg::OP_SEARCH, 5, 32'h0001_2345));
		send_cmd(mk_cmd(ple_pkg::OP_DELETE, 0, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_DELETE, 5, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_DELETE, 4, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_SEARCH, 0, 32'h7FFF_FFFF));
		send_cmd(mk_cmd(ple_pkg::OP_DELETE, 1, 32'h0));
		send_cmd(mk_cmd(ple_pkg::OP_SEARCH, 0, 32'hFFFF_FFFF));
		drain_pause();

		// Random: phases that fill, drain or mix the list
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0)
				mode = (n == 0) ? 0 : $urandom_range(0, 2);
			if (n == RAND_ITEMS / 2)
				drain_pause();
			if (n == RAND_ITEMS - CALM_ITEMS)
				idle_on = 1'b0;
			send_cmd(rand_cmd(mode, list_len_now));
		end
		cmd_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("Run covered %0d commands and %0d checked results over %0d cycles;",
			sent, checked, cycles);
		$display("the list was found full %0d times and searches hit %0d times.",
			full_hits, found_hits);
		if (fail_count == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
sv/ple_pkg.sv
sv/ple_datapath.sv
sv/ple_ctrl.sv
sv/positional_list_engine_unit.sv
tb/sv/ple_list_checker.sv
tb/sv/testbench.sv
